// File: rtl/core/gemv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gemv_pkg
// Shared types and constants of the fixed-point matrix-vector multiply core.
// ----------------------------------------------------------------------------
package gemv_pkg;

  localparam int DEF_MAX_DIM      = 64;
  localparam int DEF_MATRIX_WORDS = 4096;
  localparam int DEF_DATA_BITS    = 16;

  // Fraction bits of alpha and beta (Q4.12).
  localparam int COEF_FRAC = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_X      = 2'd1,
    OP_LOAD_Y      = 2'd2,
    OP_START       = 2'd3
  } gemv_op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ROW_COUNT     = 3'd0,
    CFG_COL_COUNT     = 3'd1,
    CFG_STORAGE_ORDER = 3'd2,
    CFG_TRANSPOSE     = 3'd3,
    CFG_LEADING_DIM   = 3'd4,
    CFG_ALPHA         = 3'd5,
    CFG_BETA          = 3'd6
  } gemv_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_ROW,
    S_INNER,
    S_DRAIN,
    S_SCALE,
    S_ROUND
  } gemv_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        index;
    logic signed [15:0] value;
  } gemv_in_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [15:0] out_value;
    logic               last;
  } gemv_out_t;

  typedef struct packed {
    logic [6:0]         row_count;
    logic [6:0]         col_count;
    logic               storage_order;
    logic               transpose;
    logic [6:0]         leading_dim;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } gemv_cfg_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic clr;    // clear accumulator at row start
    logic y_rd;   // old y read issued this cycle
    logic issue;  // matrix and x reads issued this cycle
    logic scale;  // apply alpha and beta
    logic round;  // round, saturate, write back
  } gemv_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/gemv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gemv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gemv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/gemv_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gemv_dp
// Multiply-accumulate pipeline, alpha/beta scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module gemv_dp #(
  parameter int DATA_BITS = gemv_pkg::DEF_DATA_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gemv_pkg::gemv_ctl_t    ctl,
  input  wire logic signed [((DATA_BITS < 16) ? DATA_BITS : 16)-1:0] mat_rdata,
  input  wire logic signed [((DATA_BITS < 16) ? DATA_BITS : 16)-1:0] vec_rdata,
  input  wire logic signed [15:0]     alpha,
  input  wire logic signed [15:0]     beta,
  output logic                        pipe_busy,
  output logic signed [((DATA_BITS < 16) ? DATA_BITS : 16)-1:0] y_sat
);

  localparam int DW    = (DATA_BITS < 16) ? DATA_BITS : 16;
  localparam int FRAC  = DW - 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + 7;          // 64 exact products
  localparam int AP_W  = ACC_W + 16;
  localparam int BP_W  = DW + 16;
  localparam int TW    = AP_W + 1;
  localparam int SH    = FRAC + gemv_pkg::COEF_FRAC;
  localparam int RW    = TW - SH;

  localparam logic signed [TW-1:0] RND = {{(TW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-FRAC){1'b0}}, {FRAC{1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic                    v1;
  logic                    v2;
  logic                    y_rd_d;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [DW-1:0]    y_old;
  logic signed [AP_W-1:0]  pa;
  logic signed [BP_W-1:0]  pb;
  logic signed [TW-1:0]    total;
  logic signed [RW-1:0]    r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      y_rd_d <= 1'b0;
    end else begin
      v1     <= ctl.issue;
      v2     <= v1;
      y_rd_d <= ctl.y_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= mat_rdata * vec_rdata;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (y_rd_d) begin
      y_old <= vec_rdata;
    end
    if (ctl.scale) begin
      pa <= acc * alpha;
      pb <= y_old * beta;
    end
  end

  // Floor shift of the rounded total, then clamp to the data range.
  always_comb begin
    total = TW'(pa) + (TW'(pb) <<< FRAC) + RND;
    r     = RW'(total >>> SH);
    if (r > SAT_HI) begin
      y_sat = DW'(SAT_HI);
    end else if (r < SAT_LO) begin
      y_sat = DW'(SAT_LO);
    end else begin
      y_sat = DW'(r);
    end
  end

  assign pipe_busy = v1 | v2;

endmodule
`default_nettype wire

// File: rtl/core/gemv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gemv_ctrl
// Command decode, run sequencer and modular matrix address generation.
// ----------------------------------------------------------------------------
module gemv_ctrl #(
  parameter int MAX_DIM      = gemv_pkg::DEF_MAX_DIM,
  parameter int MATRIX_WORDS = gemv_pkg::DEF_MATRIX_WORDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire gemv_pkg::gemv_in_t    cmd,
  input  wire gemv_pkg::gemv_cfg_t   cfg,
  input  wire logic                  pipe_busy,
  output logic                       busy,
  output logic                       mat_we,
  output logic [((MATRIX_WORDS > 1) ? $clog2(MATRIX_WORDS) : 1)-1:0] mat_waddr,
  output logic [((MATRIX_WORDS > 1) ? $clog2(MATRIX_WORDS) : 1)-1:0] mat_raddr,
  output logic                       vec_we,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] vec_waddr,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] vec_raddr,
  output gemv_pkg::gemv_ctl_t        ctl,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] row_idx,
  output logic                       row_last
);

  localparam int AW    = (MATRIX_WORDS > 1) ? $clog2(MATRIX_WORDS) : 1;
  localparam int SW    = AW + 1;
  localparam int VAW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam logic [AW-1:0] ONE_MOD = (MATRIX_WORDS > 1) ? AW'(1) : AW'(0);

  gemv_pkg::gemv_state_t state, state_next;

  logic [VAW-1:0]   i;
  logic [VAW-1:0]   j;
  logic [AW-1:0]    base;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    step_in;
  logic [AW-1:0]    step_out;
  logic [AW-1:0]    ld_step;
  logic [6:0]       ld_red;
  logic [DIM_W-1:0] out_len;
  logic [DIM_W-1:0] inner;
  logic             j_major;
  logic             j_last;
  logic             accept;
  logic             go;
  logic             ld_big;
  logic [DIM_W-1:0] m_eff;
  logic [DIM_W-1:0] n_eff;
  logic [DIM_W-1:0] out_len_cmd;
  logic [DIM_W-1:0] inner_cmd;

  // a + b modulo MATRIX_WORDS, both operands already reduced.
  function automatic logic [AW-1:0] addmod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [SW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SW'(MATRIX_WORDS)) begin
      s = s - SW'(MATRIX_WORDS);
    end
    return s[AW-1:0];
  endfunction

  assign busy   = (state != gemv_pkg::S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    m_eff = (32'(cfg.row_count) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.row_count);
    n_eff = (32'(cfg.col_count) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.col_count);
    out_len_cmd = cfg.transpose ? n_eff : m_eff;
    inner_cmd   = cfg.transpose ? m_eff : n_eff;
    go = accept && (cmd.operation == gemv_pkg::OP_START) &&
         (m_eff != '0) && (out_len_cmd != '0);
  end

  assign ld_big   = (32'(ld_red) >= MATRIX_WORDS);
  assign ld_step  = AW'(ld_red);
  assign j_last   = (DIM_W'(j) + DIM_W'(1) == inner);
  assign row_last = (DIM_W'(i) + DIM_W'(1) == out_len);
  assign row_idx  = i;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gemv_pkg::S_IDLE: begin
        if (go) state_next = gemv_pkg::S_REDUCE;
      end
      gemv_pkg::S_REDUCE: begin
        if (!ld_big) state_next = gemv_pkg::S_ROW;
      end
      gemv_pkg::S_ROW: begin
        state_next = (inner == '0) ? gemv_pkg::S_DRAIN : gemv_pkg::S_INNER;
      end
      gemv_pkg::S_INNER: begin
        if (j_last) state_next = gemv_pkg::S_DRAIN;
      end
      gemv_pkg::S_DRAIN: begin
        if (!pipe_busy) state_next = gemv_pkg::S_SCALE;
      end
      gemv_pkg::S_SCALE: begin
        state_next = gemv_pkg::S_ROUND;
      end
      gemv_pkg::S_ROUND: begin
        state_next = row_last ? gemv_pkg::S_IDLE : gemv_pkg::S_ROW;
      end
      default: state_next = gemv_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    mat_we    = 1'b0;
    mat_waddr = cmd.index[AW-1:0];
    mat_raddr = addr;
    vec_we    = 1'b0;
    vec_waddr = {(cmd.operation == gemv_pkg::OP_LOAD_Y), cmd.index[VAW-1:0]};
    vec_raddr = {1'b0, j};
    unique case (state)
      gemv_pkg::S_IDLE: begin
        mat_we = accept && (cmd.operation == gemv_pkg::OP_LOAD_MATRIX) &&
                 (32'(cmd.index) < MATRIX_WORDS);
        vec_we = accept && ((cmd.operation == gemv_pkg::OP_LOAD_X) ||
                            (cmd.operation == gemv_pkg::OP_LOAD_Y)) &&
                 (32'(cmd.index) < MAX_DIM);
      end
      gemv_pkg::S_ROW: begin
        ctl.clr   = 1'b1;
        ctl.y_rd  = 1'b1;
        vec_raddr = {1'b1, i};
      end
      gemv_pkg::S_INNER: begin
        ctl.issue = 1'b1;
      end
      gemv_pkg::S_SCALE: begin
        ctl.scale = 1'b1;
      end
      gemv_pkg::S_ROUND: begin
        ctl.round = 1'b1;
        vec_we    = 1'b1;
        vec_waddr = {1'b1, i};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gemv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gemv_pkg::S_IDLE: begin
        if (go) begin
          out_len <= out_len_cmd;
          inner   <= inner_cmd;
          j_major <= (cfg.storage_order == cfg.transpose);
          ld_red  <= cfg.leading_dim;
          i       <= '0;
          base    <= '0;
        end
      end
      gemv_pkg::S_REDUCE: begin
        if (ld_big) begin
          ld_red <= ld_red - 7'(MATRIX_WORDS);
        end
        step_in  <= j_major ? ld_step : ONE_MOD;
        step_out <= j_major ? ONE_MOD : ld_step;
      end
      gemv_pkg::S_ROW: begin
        addr <= base;
        j    <= '0;
      end
      gemv_pkg::S_INNER: begin
        addr <= addmod(addr, step_in);
        j    <= j + VAW'(1);
      end
      gemv_pkg::S_ROUND: begin
        i    <= i + VAW'(1);
        base <= addmod(base, step_out);
      end
      default: begin
      end
    endcase
  end

  a_inner_bound: assert property (@(posedge clk) disable iff (rst)
    state == gemv_pkg::S_INNER |-> DIM_W'(j) < inner)
    else $error("inner index past inner length");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    state == gemv_pkg::S_INNER |-> 32'(addr) < MATRIX_WORDS)
    else $error("matrix read address not reduced");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == gemv_pkg::S_SCALE |-> !pipe_busy)
    else $error("scaling before accumulator drained");

endmodule
`default_nettype wire

// File: rtl/core/general_matrix_vector_multiply_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// general_matrix_vector_multiply_core
// Fixed-point y = alpha*op(A)*x + beta*y over RAM-held A, x and y.
// ----------------------------------------------------------------------------
// Loads (matrix, x, y) leave busy low, so while idle the core takes one load per cycle.
// A start holds busy from the reduce state through each row's row, inner, drain, scale
// and round states, with no inner state when inner == 0; the per-row cost is set by
// the single matrix read port feeding one multiply-accumulate per cycle.
// Each result strobes on done for one cycle, in the cycle after its row's round state.
// Synchronous reset returns the sequencer to idle and the configuration to its defaults; RAM contents are kept.
module general_matrix_vector_multiply_core #(
  parameter int MAX_DIM      = gemv_pkg::DEF_MAX_DIM,
  parameter int MATRIX_WORDS = gemv_pkg::DEF_MATRIX_WORDS,
  parameter int DATA_BITS    = gemv_pkg::DEF_DATA_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // command channel
  input  wire logic                                  start,
  input  wire gemv_pkg::gemv_in_t                    cmd,
  output logic                                       busy,
  // result channel, no back-pressure
  output logic                                       done,
  output gemv_pkg::gemv_out_t                        result,
  // configuration write port
  input  wire logic                                  cfg_write,
  input  wire logic [gemv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [gemv_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Stored word width; values are Q1.(DW-1).
  localparam int DW  = (DATA_BITS < 16) ? DATA_BITS : 16;
  localparam int AW  = (MATRIX_WORDS > 1) ? $clog2(MATRIX_WORDS) : 1;
  localparam int VAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  // x in the lower half, y in the upper half of the vector RAM.
  localparam int VEC_DEPTH = 2 << VAW;

  gemv_pkg::gemv_cfg_t cfg;
  gemv_pkg::gemv_ctl_t ctl;

  logic                 pipe_busy;
  logic                 mat_we;
  logic [AW-1:0]        mat_waddr;
  logic [AW-1:0]        mat_raddr;
  logic [DW-1:0]        mat_rdata;
  logic                 vec_we;
  logic [VAW:0]         vec_waddr;
  logic [VAW:0]         vec_raddr;
  logic [DW-1:0]        vec_wdata;
  logic [DW-1:0]        vec_rdata;
  logic signed [DW-1:0] y_sat;
  logic [VAW-1:0]       row_idx;
  logic                 row_last;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count     <= 7'd0;
      cfg.col_count     <= 7'd0;
      cfg.storage_order <= 1'b0;
      cfg.transpose     <= 1'b0;
      cfg.leading_dim   <= 7'd64;
      cfg.alpha         <= 16'sd4096;
      cfg.beta          <= 16'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gemv_pkg::CFG_ROW_COUNT:     cfg.row_count     <= cfg_data[6:0];
        gemv_pkg::CFG_COL_COUNT:     cfg.col_count     <= cfg_data[6:0];
        gemv_pkg::CFG_STORAGE_ORDER: cfg.storage_order <= cfg_data[0];
        gemv_pkg::CFG_TRANSPOSE:     cfg.transpose     <= cfg_data[0];
        gemv_pkg::CFG_LEADING_DIM:   cfg.leading_dim   <= cfg_data[6:0];
        gemv_pkg::CFG_ALPHA:         cfg.alpha         <= signed'(cfg_data);
        gemv_pkg::CFG_BETA:          cfg.beta          <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  gemv_ctrl #(
    .MAX_DIM      (MAX_DIM),
    .MATRIX_WORDS (MATRIX_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_raddr (mat_raddr),
    .vec_we    (vec_we),
    .vec_waddr (vec_waddr),
    .vec_raddr (vec_raddr),
    .ctl       (ctl),
    .row_idx   (row_idx),
    .row_last  (row_last)
  );

  // Matrix store, addressed by storage address.
  gemv_ram #(
    .WIDTH (DW),
    .DEPTH (MATRIX_WORDS)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cmd.value[DW-1:0]),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // Loads write the command value; a finished row writes its new y.
  assign vec_wdata = ctl.round ? y_sat : cmd.value[DW-1:0];

  gemv_ram #(
    .WIDTH (DW),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  gemv_dp #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .mat_rdata (signed'(mat_rdata)),
    .vec_rdata (signed'(vec_rdata)),
    .alpha     (cfg.alpha),
    .beta      (cfg.beta),
    .pipe_busy (pipe_busy),
    .y_sat     (y_sat)
  );

  // Result register: one transaction per finished row.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.round;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      result.out_index <= 6'(row_idx);
      result.out_value <= 16'(y_sat);
      result.last      <= row_last;
    end
  end

  // The final row returns the sequencer to idle; any earlier row continues the run.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> !busy)
    else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy)
    else $error("run ended without final result");

endmodule
`default_nettype wire
